// ----- sv/bsd_pkg.sv -----
// Shared types and constants for the BMP stream pixel decoder.
package bsd_pkg;

    localparam int DEFAULT_MAX_DIMENSION = 4096;
    localparam int HDR_BYTES             = 54;
    localparam int HDR_SIZE_40           = 40;
    localparam int BPP_24                = 24;
    localparam int BPP_32                = 32;
    localparam logic [7:0] SIG_B         = 8'h42;
    localparam logic [7:0] SIG_M         = 8'h4D;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [3:0] RSN_NONE        = 4'd0;
    localparam logic [3:0] RSN_SHORT       = 4'd1;
    localparam logic [3:0] RSN_SIGNATURE   = 4'd2;
    localparam logic [3:0] RSN_HDR_SIZE    = 4'd3;
    localparam logic [3:0] RSN_WIDTH       = 4'd4;
    localparam logic [3:0] RSN_HEIGHT      = 4'd5;
    localparam logic [3:0] RSN_COMPRESSION = 4'd6;
    localparam logic [3:0] RSN_DEPTH       = 4'd7;
    localparam logic [3:0] RSN_DATA_SHORT  = 4'd8;
    localparam logic [3:0] RSN_OFFSET      = 4'd9;

    typedef struct packed {
        logic       accept;
        logic       last;
        logic       hdr_end;
        logic [3:0] hdr_reason;
        logic       offset_past_hdr;
        logic       skip_reached;
        logic       pix_emit;
        logic       row_done;
    } status_t;

    typedef struct packed {
        logic       capture;
        logic       pix_step;
        logic       emit;
        logic [1:0] kind;
        logic [3:0] reason;
        logic       clear;
    } cmd_t;

endpackage

// ----- sv/bsd_ctrl.sv -----
// Phase controller: header, skip, pixel and drain sequencing.
module bsd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  bsd_pkg::status_t status,
    output bsd_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_DRAIN
    } phase_t;

    phase_t     state_reg;
    phase_t     state_next;
    logic [3:0] hdr_rsn;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        hdr_rsn    = status.hdr_reason;
        if (status.accept)
        begin
            case (state_reg)
                PH_HEADER:
                begin
                    cmd.capture = 1'b1;
                    if (status.hdr_end)
                    begin
                        if (hdr_rsn == bsd_pkg::RSN_NONE && status.last)
                        begin
                            hdr_rsn = bsd_pkg::RSN_DATA_SHORT;
                        end
                        cmd.emit = 1'b1;
                        if (hdr_rsn != bsd_pkg::RSN_NONE)
                        begin
                            cmd.kind   = bsd_pkg::KIND_REJECT;
                            cmd.reason = hdr_rsn;
                            state_next = PH_DRAIN;
                        end
                        else
                        begin
                            cmd.kind   = bsd_pkg::KIND_HEADER;
                            state_next = status.offset_past_hdr ? PH_SKIP : PH_PIXEL;
                        end
                    end
                    else if (status.last)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = bsd_pkg::KIND_REJECT;
                        cmd.reason = bsd_pkg::RSN_SHORT;
                    end
                end
                PH_SKIP, PH_PIXEL:
                begin
                    cmd.pix_step = (state_reg == PH_PIXEL) || status.skip_reached;
                    if (cmd.pix_step && status.pix_emit)
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = bsd_pkg::KIND_PIXEL;
                    end
                    if (status.last && !(cmd.pix_step && status.row_done))
                    begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = bsd_pkg::KIND_REJECT;
                        cmd.reason = bsd_pkg::RSN_DATA_SHORT;
                    end
                    if (cmd.pix_step)
                    begin
                        state_next = status.row_done ? PH_DRAIN : PH_PIXEL;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
            if (status.last)
            begin
                cmd.clear  = 1'b1;
                state_next = PH_HEADER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/bsd_datapath.sv -----
// Datapath: byte counter, header fields, header check, pixel assembly, result register.
module bsd_datapath #(
    parameter int MAX_DIMENSION = bsd_pkg::DEFAULT_MAX_DIMENSION
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic [31:0]      file_length,
    input  logic             last_byte,
    input  logic             out_stall,
    input  bsd_pkg::cmd_t    cmd,
    output bsd_pkg::status_t status,
    output logic             out_valid,
    output logic [1:0]       result_kind,
    output logic [3:0]       reject_reason,
    output logic [23:0]      pixel_rgb,
    output logic [11:0]      column,
    output logic [11:0]      dest_row,
    output logic [12:0]      image_width,
    output logic [12:0]      image_height,
    output logic             end_of_image
);

    localparam int DW     = $clog2(MAX_DIMENSION + 1);
    localparam int SW     = DW + 2;
    localparam int PW     = SW + DW;
    localparam int NEED_W = (2 * DW + 3 > 33) ? 2 * DW + 3 : 33;

    logic [31:0]     byte_count_reg;
    logic [7:0]      sig0_reg;
    logic [7:0]      sig1_reg;
    logic [31:0]     offset_reg;
    logic [31:0]     hsize_reg;
    logic [31:0]     width_reg;
    logic [31:0]     height_reg;
    logic [15:0]     bpp_reg;
    logic [31:0]     comp_reg;
    logic [31:0]     hmag_reg;
    logic            rows_down_reg;
    logic [SW-1:0]   wbytes_reg;
    logic [SW-1:0]   stride_reg;
    logic [DW-1:0]   wm1_reg;
    logic [DW-1:0]   hm1_reg;
    logic [PW-1:0]   prod_reg;
    logic [NEED_W-1:0] need_reg;

    logic [DW-1:0]   col_reg;
    logic [DW-1:0]   srow_reg;
    logic [1:0]      bip_reg;
    logic [SW-1:0]   rbp_reg;
    logic [15:0]     partial_reg;

    logic            ov_reg;
    logic [1:0]      kind_reg;
    logic [3:0]      rsn_reg;
    logic [23:0]     rgb_reg;
    logic [11:0]     colo_reg;
    logic [11:0]     rowo_reg;
    logic [12:0]     iw_reg;
    logic [12:0]     ih_reg;
    logic            eoi_reg;

    logic [5:0]      idx6;
    logic [5:0]      rel_off;
    logic [5:0]      rel_hs;
    logic [5:0]      rel_w;
    logic [5:0]      rel_h;
    logic [5:0]      rel_c;
    logic            is32;
    logic [DW-1:0]   w_dw;
    logic [SW-1:0]   wbytes_calc;
    logic [SW-1:0]   rbp_inc;
    logic            in_row;
    logic            pix_last;
    logic            row_end;
    logic [DW-1:0]   dest_calc;
    logic [3:0]      reason;

    assign idx6    = byte_count_reg[5:0];
    assign rel_off = idx6 - 6'd10;
    assign rel_hs  = idx6 - 6'd14;
    assign rel_w   = idx6 - 6'd18;
    assign rel_h   = idx6 - 6'd22;
    assign rel_c   = idx6 - 6'd30;
    assign is32    = (bpp_reg == 16'(bsd_pkg::BPP_32));
    assign w_dw    = width_reg[DW-1:0];
    assign wbytes_calc = is32 ? {w_dw, 2'b00} : ({2'b00, w_dw} + {1'b0, w_dw, 1'b0});

    assign in_row   = rbp_reg < wbytes_reg;
    assign pix_last = is32 ? (bip_reg == 2'd3) : (bip_reg == 2'd2);
    assign rbp_inc  = rbp_reg + 1'b1;
    assign row_end  = (rbp_inc == stride_reg);
    assign dest_calc = rows_down_reg ? srow_reg : (hm1_reg - srow_reg);

    always_comb
    begin
        if (file_length < 32'(bsd_pkg::HDR_BYTES))
            reason = bsd_pkg::RSN_SHORT;
        else if (sig0_reg != bsd_pkg::SIG_B || sig1_reg != bsd_pkg::SIG_M)
            reason = bsd_pkg::RSN_SIGNATURE;
        else if (hsize_reg != 32'(bsd_pkg::HDR_SIZE_40))
            reason = bsd_pkg::RSN_HDR_SIZE;
        else if (width_reg == 32'd0 || width_reg > 32'(MAX_DIMENSION))
            reason = bsd_pkg::RSN_WIDTH;
        else if (hmag_reg == 32'd0 || hmag_reg > 32'(MAX_DIMENSION))
            reason = bsd_pkg::RSN_HEIGHT;
        else if (comp_reg != 32'd0)
            reason = bsd_pkg::RSN_COMPRESSION;
        else if (bpp_reg != 16'(bsd_pkg::BPP_24) && !is32)
            reason = bsd_pkg::RSN_DEPTH;
        else if (need_reg > NEED_W'(file_length))
            reason = bsd_pkg::RSN_DATA_SHORT;
        else if (offset_reg < 32'(bsd_pkg::HDR_BYTES))
            reason = bsd_pkg::RSN_OFFSET;
        else
            reason = bsd_pkg::RSN_NONE;
    end

    always_comb
    begin
        status                 = '0;
        status.accept          = accept;
        status.last            = last_byte;
        status.hdr_end         = (byte_count_reg == 32'(bsd_pkg::HDR_BYTES - 1));
        status.hdr_reason      = reason;
        status.offset_past_hdr = offset_reg > 32'(bsd_pkg::HDR_BYTES);
        status.skip_reached    = byte_count_reg >= offset_reg;
        status.pix_emit        = in_row && (bip_reg == 2'd2);
        status.row_done        = row_end && (srow_reg == hm1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.capture && byte_count_reg < 32'(bsd_pkg::HDR_BYTES))
        begin
            case (idx6) inside
                6'd0:            sig0_reg <= data_byte;
                6'd1:            sig1_reg <= data_byte;
                [6'd10:6'd13]:   offset_reg[rel_off[1:0]*8 +: 8] <= data_byte;
                [6'd14:6'd17]:   hsize_reg[rel_hs[1:0]*8 +: 8] <= data_byte;
                [6'd18:6'd21]:   width_reg[rel_w[1:0]*8 +: 8] <= data_byte;
                [6'd22:6'd25]:   height_reg[rel_h[1:0]*8 +: 8] <= data_byte;
                6'd28:           bpp_reg[7:0] <= data_byte;
                6'd29:           bpp_reg[15:8] <= data_byte;
                [6'd30:6'd33]:   comp_reg[rel_c[1:0]*8 +: 8] <= data_byte;
                6'd34:
                begin
                    hmag_reg      <= height_reg[31] ? (32'd0 - height_reg) : height_reg;
                    rows_down_reg <= height_reg[31];
                    wbytes_reg    <= wbytes_calc;
                    wm1_reg       <= w_dw - 1'b1;
                end
                6'd35:
                begin
                    stride_reg <= (wbytes_reg + SW'(3)) & ~SW'(3);
                    hm1_reg    <= hmag_reg[DW-1:0] - 1'b1;
                end
                6'd36:           prod_reg <= PW'(stride_reg) * PW'(hmag_reg[DW-1:0]);
                6'd37:           need_reg <= NEED_W'(offset_reg) + NEED_W'(prod_reg);
                default:
                begin
                    sig0_reg <= sig0_reg;
                end
            endcase
        end
        if (accept && cmd.pix_step && in_row)
        begin
            if (bip_reg == 2'd0)
                partial_reg <= {8'd0, data_byte};
            else if (bip_reg == 2'd1)
                partial_reg <= {data_byte, partial_reg[7:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            col_reg        <= '0;
            srow_reg       <= '0;
            bip_reg        <= '0;
            rbp_reg        <= '0;
        end
        else if (accept)
        begin
            byte_count_reg <= byte_count_reg + 32'd1;
            if (cmd.pix_step)
            begin
                if (in_row)
                begin
                    if (pix_last)
                    begin
                        bip_reg <= '0;
                        col_reg <= col_reg + 1'b1;
                    end
                    else
                    begin
                        bip_reg <= bip_reg + 2'd1;
                    end
                end
                rbp_reg <= rbp_inc;
                if (row_end)
                begin
                    rbp_reg  <= '0;
                    col_reg  <= '0;
                    bip_reg  <= '0;
                    srow_reg <= srow_reg + 1'b1;
                end
            end
            if (cmd.clear)
            begin
                byte_count_reg <= '0;
                col_reg        <= '0;
                srow_reg       <= '0;
                bip_reg        <= '0;
                rbp_reg        <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ov_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg <= cmd.kind;
            rsn_reg  <= cmd.reason;
            rgb_reg  <= '0;
            colo_reg <= '0;
            rowo_reg <= '0;
            eoi_reg  <= 1'b0;
            iw_reg   <= 13'(width_reg);
            ih_reg   <= 13'(hmag_reg);
            case (cmd.kind)
                bsd_pkg::KIND_PIXEL:
                begin
                    rgb_reg  <= {data_byte, partial_reg};
                    colo_reg <= 12'(col_reg);
                    rowo_reg <= 12'(dest_calc);
                    eoi_reg  <= (col_reg == wm1_reg) && (srow_reg == hm1_reg);
                end
                bsd_pkg::KIND_REJECT:
                begin
                    iw_reg <= '0;
                    ih_reg <= '0;
                end
                default:
                begin
                    eoi_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid     = ov_reg;
    assign result_kind   = kind_reg;
    assign reject_reason = rsn_reg;
    assign pixel_rgb     = rgb_reg;
    assign column        = colo_reg;
    assign dest_row      = rowo_reg;
    assign image_width   = iw_reg;
    assign image_height  = ih_reg;
    assign end_of_image  = eoi_reg;

endmodule

// ----- sv/bmp_stream_pixel_decoder.sv -----
// Top level of the BMP stream pixel decoder: controller plus datapath.
//
//   channel | signals                                  | direction
//   input   | in_valid, in_stall, data_byte,           | byte in
//           | file_length, last_byte                   |
//   output  | out_valid, out_stall, result_kind, ...   | result out
//
// One byte per cycle while in_stall is low; a byte's result, if it has one, is registered and
// shows on the output in the cycle after the transfer.
// A result sits in one output register; a new byte is taken while that
// register is empty or being emptied, so in_stall follows a held result.
// Reset returns to the header phase; last_byte does the same per file.
module bmp_stream_pixel_decoder #(
    parameter int MAX_DIMENSION = bsd_pkg::DEFAULT_MAX_DIMENSION
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [31:0] file_length,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [3:0]  reject_reason,
    output logic [23:0] pixel_rgb,
    output logic [11:0] column,
    output logic [11:0] dest_row,
    output logic [12:0] image_width,
    output logic [12:0] image_height,
    output logic        end_of_image
);

    bsd_pkg::status_t status;
    bsd_pkg::cmd_t    cmd;
    logic             accept;

    assign in_stall = out_valid & out_stall;
    assign accept   = in_valid & ~in_stall;

    bsd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    bsd_datapath #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .file_length   (file_length),
        .last_byte     (last_byte),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .result_kind   (result_kind),
        .reject_reason (reject_reason),
        .pixel_rgb     (pixel_rgb),
        .column        (column),
        .dest_row      (dest_row),
        .image_width   (image_width),
        .image_height  (image_height),
        .end_of_image  (end_of_image)
    );

endmodule

// ----- sv/bsd_checker.sv -----
// Port-level checks for the BMP stream pixel decoder, bound to the top level.
module bsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_kind,
    input logic [3:0]  reject_reason,
    input logic [12:0] image_width,
    input logic [12:0] image_height
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind))
        else $error("held result changed");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall without a held result");

    a_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != bsd_pkg::KIND_REJECT |-> reject_reason == bsd_pkg::RSN_NONE)
        else $error("reason on a non-reject transfer");

    a_dims: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == bsd_pkg::KIND_PIXEL |-> image_width != 13'd0
            && image_height != 13'd0 && reject_reason == bsd_pkg::RSN_NONE)
        else $error("pixel without image size");

endmodule

bind bmp_stream_pixel_decoder bsd_checker u_chk (.*);
